/* hw/rtl/clti_pkg.sv */
// Package for the core-local timer interruptor: beat types, request, region
// and status codes, and default parameter values. No dependencies.
package clti_pkg;

  localparam int HART_COUNT_DEF          = 4;
  localparam int SOFT_REGION_BASE_DEF    = 0;
  localparam int COMPARE_REGION_BASE_DEF = 16384;
  localparam int TIME_REG_BASE_DEF       = 49144;

  // Number of harts whose pending bits appear on the result beat.
  localparam int SHOWN_HARTS = 4;

  localparam logic [31:0] LOW_WORD = 32'hFFFF_FFFF;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_RO   = 2'd2,
    ST_RSVD = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    RGN_NONE = 2'd0,
    RGN_SOFT = 2'd1,
    RGN_CMP  = 2'd2,
    RGN_TIME = 2'd3
  } region_e_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic        wide;
    logic [63:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [63:0] rdata;
    logic [1:0]  status;
    logic [3:0]  soft_pending;
    logic [3:0]  timer_pending;
  } out_item_t;

  // Result of the address decode for one register access.
  typedef struct packed {
    region_e_t region;
    logic      hi_half;
    logic      err;
  } dec_t;

endpackage

/* hw/rtl/clti_decode.sv */
// Address decoder for the core-local timer interruptor: region hit, hart
// index, half select and error checks. Depends on clti_pkg.
module clti_decode #(
  parameter int HART_COUNT          = clti_pkg::HART_COUNT_DEF,
  parameter int SOFT_REGION_BASE    = clti_pkg::SOFT_REGION_BASE_DEF,
  parameter int COMPARE_REGION_BASE = clti_pkg::COMPARE_REGION_BASE_DEF,
  parameter int TIME_REG_BASE       = clti_pkg::TIME_REG_BASE_DEF,
  localparam int HW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1
) (
  input  logic [1:0]    req_type,
  input  logic [15:0]   addr,
  input  logic          wide,
  output clti_pkg::dec_t dec,
  output logic [HW-1:0] hart
);

  localparam int SOFT_END = SOFT_REGION_BASE + 4 * HART_COUNT;
  localparam int CMP_END  = COMPARE_REGION_BASE + 8 * HART_COUNT;
  localparam int TIME_END = TIME_REG_BASE + 8;

  localparam logic [17:0] SOFT_LO = SOFT_REGION_BASE[17:0];
  localparam logic [17:0] SOFT_HI = SOFT_END[17:0];
  localparam logic [17:0] CMP_LO  = COMPARE_REGION_BASE[17:0];
  localparam logic [17:0] CMP_HI  = CMP_END[17:0];
  localparam logic [17:0] TIME_LO = TIME_REG_BASE[17:0];
  localparam logic [17:0] TIME_HI = TIME_END[17:0];

  logic [17:0] addr_x;
  logic [15:0] soft_off;
  logic [15:0] cmp_off;
  logic [15:0] time_off;
  logic        soft_hit;
  logic        cmp_hit;
  logic        time_hit;
  logic        bad_req;

  assign addr_x   = {2'b00, addr};
  assign soft_off = addr - SOFT_REGION_BASE[15:0];
  assign cmp_off  = addr - COMPARE_REGION_BASE[15:0];
  assign time_off = addr - TIME_REG_BASE[15:0];
  assign soft_hit = (addr_x >= SOFT_LO) && (addr_x < SOFT_HI);
  assign cmp_hit  = (addr_x >= CMP_LO) && (addr_x < CMP_HI);
  assign time_hit = (addr_x >= TIME_LO) && (addr_x < TIME_HI);
  assign bad_req  = (req_type == clti_pkg::REQ_RSVD) || (addr[1:0] != 2'b00);

  // Regions are tried in a fixed order so that overlapping bases resolve
  // to the software bits first, then the compare values, then the counter.
  always_comb begin
    dec.region  = clti_pkg::RGN_NONE;
    dec.hi_half = 1'b0;
    dec.err     = 1'b1;
    hart        = '0;
    if (soft_hit) begin
      dec.region = clti_pkg::RGN_SOFT;
      dec.err    = wide;
      hart       = soft_off[HW+1:2];
    end else if (cmp_hit) begin
      dec.region  = clti_pkg::RGN_CMP;
      dec.err     = wide && (cmp_off[2:0] != 3'd0);
      dec.hi_half = cmp_off[2];
      hart        = cmp_off[HW+2:3];
    end else if (time_hit) begin
      dec.region  = clti_pkg::RGN_TIME;
      dec.err     = wide && (time_off[2:0] != 3'd0);
      dec.hi_half = time_off[2];
    end
    if (bad_req) begin
      dec.err = 1'b1;
    end
  end

endmodule

/* hw/rtl/core_local_timer_interruptor_core.sv */
// Top level of the core-local timer interruptor: input register, state
// update and result register. Depends on clti_pkg and clti_decode.

// Takes one beat per clock while the result side is not stalled: a timer
// tick, a register read or a register write, and returns exactly one result
// beat for each, after the beat has passed the input register and the result
// register. The register file (time counter, per-hart software bits and
// compare values) is updated between the input register and the result
// register. Each result carries the software and timer pending bits of harts
// 0 to 3 as they stand after that beat; a timer is pending while the time
// counter is at or above its compare value. Compare values come out of reset
// as all ones, so timers start disabled.
module core_local_timer_interruptor_core #(
  parameter int HART_COUNT          = clti_pkg::HART_COUNT_DEF,
  parameter int SOFT_REGION_BASE    = clti_pkg::SOFT_REGION_BASE_DEF,
  parameter int COMPARE_REGION_BASE = clti_pkg::COMPARE_REGION_BASE_DEF,
  parameter int TIME_REG_BASE       = clti_pkg::TIME_REG_BASE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clti_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output clti_pkg::out_item_t out_item
);

  localparam int HW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;

  clti_pkg::in_item_t  in_q_r;
  logic                in_valid_r;
  clti_pkg::out_item_t out_q_r;
  clti_pkg::out_item_t out_q_nxt;
  logic                out_valid_r;

  logic [63:0]           time_r;
  logic [63:0]           time_nxt;
  logic [HART_COUNT-1:0] soft_r;
  logic [HART_COUNT-1:0] soft_nxt;
  logic [63:0]           cmp_r   [HART_COUNT];
  logic [63:0]           cmp_nxt [HART_COUNT];

  clti_pkg::dec_t dec;
  logic [HW-1:0]  hart;
  logic           advance;
  logic           is_tick;
  logic           is_write;
  logic           do_soft_wr;
  logic           do_cmp_wr;
  logic [63:0]    cmp_sel;
  logic [63:0]    rdata;
  logic [1:0]     status;
  logic [clti_pkg::SHOWN_HARTS-1:0] soft_pend;
  logic [clti_pkg::SHOWN_HARTS-1:0] tmr_pend;

  clti_decode #(
    .HART_COUNT          (HART_COUNT),
    .SOFT_REGION_BASE    (SOFT_REGION_BASE),
    .COMPARE_REGION_BASE (COMPARE_REGION_BASE),
    .TIME_REG_BASE       (TIME_REG_BASE)
  ) u_decode (
    .req_type (in_q_r.req_type),
    .addr     (in_q_r.addr),
    .wide     (in_q_r.wide),
    .dec      (dec),
    .hart     (hart)
  );

  // The held beat moves on whenever the result register is free or drained.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_q_r;

  assign is_tick    = (in_q_r.req_type == clti_pkg::REQ_TICK);
  assign is_write   = (in_q_r.req_type == clti_pkg::REQ_WRITE);
  assign do_soft_wr = advance && is_write && !dec.err && (dec.region == clti_pkg::RGN_SOFT);
  assign do_cmp_wr  = advance && is_write && !dec.err && (dec.region == clti_pkg::RGN_CMP);
  assign cmp_sel    = cmp_r[hart];

  always_comb begin
    time_nxt = time_r;
    if (advance && is_tick) begin
      time_nxt = time_r + 64'd1;
    end
  end

  always_comb begin
    for (int h = 0; h < HART_COUNT; h++) begin
      soft_nxt[h] = soft_r[h];
      cmp_nxt[h]  = cmp_r[h];
      if (do_soft_wr && (hart == HW'(h))) begin
        soft_nxt[h] = in_q_r.wdata[0];
      end
      if (do_cmp_wr && (hart == HW'(h))) begin
        if (in_q_r.wide) begin
          cmp_nxt[h] = in_q_r.wdata;
        end else if (dec.hi_half) begin
          cmp_nxt[h] = {in_q_r.wdata[31:0], cmp_r[h][31:0]};
        end else begin
          cmp_nxt[h] = {cmp_r[h][63:32], in_q_r.wdata[31:0]};
        end
      end
    end
  end

  always_comb begin
    rdata  = '0;
    status = clti_pkg::ST_OK;
    if (!is_tick) begin
      if (dec.err) begin
        status = clti_pkg::ST_ERR;
      end else if (is_write) begin
        if (dec.region == clti_pkg::RGN_TIME) begin
          status = clti_pkg::ST_RO;
        end
      end else begin
        case (dec.region)
          clti_pkg::RGN_SOFT: rdata = {63'd0, soft_r[hart]};
          clti_pkg::RGN_CMP: begin
            if (in_q_r.wide) begin
              rdata = cmp_sel;
            end else if (dec.hi_half) begin
              rdata = {32'd0, cmp_sel[63:32]};
            end else begin
              rdata = {32'd0, cmp_sel[31:0] & clti_pkg::LOW_WORD};
            end
          end
          clti_pkg::RGN_TIME: begin
            if (in_q_r.wide) begin
              rdata = time_r;
            end else if (dec.hi_half) begin
              rdata = {32'd0, time_r[63:32]};
            end else begin
              rdata = {32'd0, time_r[31:0] & clti_pkg::LOW_WORD};
            end
          end
          default: rdata = '0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < clti_pkg::SHOWN_HARTS; g++) begin : g_pend
    if (g < HART_COUNT) begin : g_live
      assign soft_pend[g] = soft_nxt[g];
      assign tmr_pend[g]  = (time_nxt >= cmp_nxt[g]);
    end else begin : g_absent
      assign soft_pend[g] = 1'b0;
      assign tmr_pend[g]  = 1'b0;
    end
  end

  always_comb begin
    out_q_nxt.rdata         = rdata;
    out_q_nxt.status        = status;
    out_q_nxt.soft_pending  = soft_pend;
    out_q_nxt.timer_pending = tmr_pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      time_r      <= '0;
      soft_r      <= '0;
      for (int h = 0; h < HART_COUNT; h++) begin
        cmp_r[h] <= clti_pkg::ALL_ONES;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      time_r <= time_nxt;
      soft_r <= soft_nxt;
      for (int h = 0; h < HART_COUNT; h++) begin
        cmp_r[h] <= cmp_nxt[h];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_item;
    end
    if (advance) begin
      out_q_r <= out_q_nxt;
    end
  end

endmodule

/* hw/rtl/clti_checker.sv */
// Port-level checks for the core-local timer interruptor, bound to the top
// level. Depends on clti_pkg and core_local_timer_interruptor_core.
module clti_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input clti_pkg::out_item_t out_item
);

  // A result beat that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // Input is only refused while a result waits to be taken.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without an output stall");

  // Once an accepted beat has passed the input register, the result register holds a valid beat.
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result after an accepted beat");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind core_local_timer_interruptor_core clti_port_checks u_clti_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
